// ===== design/ucl_pkg.sv =====
// Shared types, codes and sizes of the UART console line buffer.
package ucl_pkg;

	// Ring sizes and derived pointer/count widths
	localparam int RX_DEPTH = 16;
	localparam int TX_DEPTH = 16;
	localparam int RX_AW    = $clog2(RX_DEPTH);
	localparam int TX_AW    = $clog2(TX_DEPTH);
	localparam int RX_CW    = $clog2(RX_DEPTH + 1);
	localparam int TX_CW    = $clog2(TX_DEPTH + 1);
	localparam int RX_SW    = RX_AW + 1;
	localparam int TX_SW    = TX_AW + 1;

	// Event codes
	localparam logic [1:0] FUNC_RX_BYTE   = 2'd0;
	localparam logic [1:0] FUNC_TX_DONE   = 2'd1;
	localparam logic [1:0] FUNC_APP_WRITE = 2'd2;
	localparam logic [1:0] FUNC_APP_READ  = 2'd3;

	// Character codes
	localparam logic [7:0] CH_ETX = 8'h04;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic       tx_load;
		logic [7:0] tx_byte;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       read_end;
		logic       write_accepted;
		logic       rx_overflow;
	} out_item_t;

	typedef struct packed {
		logic             we;
		logic [RX_AW-1:0] waddr;
		logic [7:0]       wdata;
		logic [RX_AW-1:0] raddr;
	} rx_mem_req_t;

	typedef struct packed {
		logic             we;
		logic [TX_AW-1:0] waddr;
		logic [7:0]       wdata;
		logic [TX_AW-1:0] raddr;
	} tx_mem_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH2,
		ST_FETCH
	} state_t;

endpackage

// ===== design/ucl_in_if.sv =====
// Input event channel: valid/ready handshake with one event item.
interface ucl_in_if import ucl_pkg::*;;
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/ucl_out_if.sv =====
// Result channel: valid/ready handshake with one result item.
interface ucl_out_if import ucl_pkg::*;;
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/ucl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ucl_ram #(
	parameter int Depth = 16,
	parameter int Width = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== design/ucl_ctrl.sv =====
// Event sequencer: ring pointers, busy flag, memory requests and result register.
module ucl_ctrl import ucl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ucl_in_if.sink       in_ch,
	ucl_out_if.source    out_ch,
	output rx_mem_req_t  rx_req,
	input  logic [7:0]   rx_rdata,
	output tx_mem_req_t  tx_req,
	input  logic [7:0]   tx_rdata
);

	state_t           state_q, state_d;
	logic [RX_AW-1:0] rx_head_q, rx_head_d;
	logic [RX_CW-1:0] rx_cnt_q, rx_cnt_d;
	logic [TX_AW-1:0] tx_head_q, tx_head_d;
	logic [TX_CW-1:0] tx_cnt_q, tx_cnt_d;
	logic             tx_busy_q, tx_busy_d;
	logic             fetch_rx_q;
	logic             out_valid_q;
	out_item_t        out_q, out_d;
	logic             out_load;

	logic             accept;
	logic [1:0]       func;
	logic [7:0]       ch_in;
	logic [7:0]       rx_byte;
	logic [7:0]       send_byte;
	logic [7:0]       first_byte;
	logic             send_lf;
	logic             send_en;
	logic             tx_room;
	logic             rx_full;
	logic [TX_CW-1:0] wr_need;
	logic             wr_room;
	logic [RX_SW-1:0] rx_sum;
	logic [TX_SW-1:0] tx_sum;
	logic [RX_AW-1:0] rx_tail;
	logic [TX_AW-1:0] tx_tail;
	logic [RX_AW-1:0] rx_head_inc;
	logic [TX_AW-1:0] tx_head_inc;

	// Take a new event only when idle and the result register is free
	assign in_ch.ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ch.ready);
	assign accept       = in_ch.valid && in_ch.ready;
	assign func         = in_ch.data.func;
	assign ch_in        = in_ch.data.data_byte;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	// Ring tail and head-advance arithmetic
	always_comb begin
		rx_sum  = RX_SW'(rx_head_q) + RX_SW'(rx_cnt_q);
		tx_sum  = TX_SW'(tx_head_q) + TX_SW'(tx_cnt_q);
		rx_tail = (rx_sum >= RX_SW'(RX_DEPTH)) ? RX_AW'(rx_sum - RX_SW'(RX_DEPTH))
		                                        : RX_AW'(rx_sum);
		tx_tail = (tx_sum >= TX_SW'(TX_DEPTH)) ? TX_AW'(tx_sum - TX_SW'(TX_DEPTH))
		                                        : TX_AW'(tx_sum);
		rx_head_inc = (rx_head_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_q + RX_AW'(1);
		tx_head_inc = (tx_head_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_q + TX_AW'(1);
		rx_full     = (rx_cnt_q == RX_CW'(RX_DEPTH));
		tx_room     = (tx_cnt_q != TX_CW'(TX_DEPTH));
	end

	// Decode what gets sent: echo of a received byte or an application write
	always_comb begin
		rx_byte    = (ch_in == CH_CR) ? CH_LF : ch_in;
		send_byte  = (func == FUNC_RX_BYTE) ? rx_byte : ch_in;
		send_lf    = (send_byte == CH_LF);
		first_byte = send_lf ? CH_CR : send_byte;
		if (tx_busy_q) begin
			wr_need = send_lf ? TX_CW'(2) : TX_CW'(1);
		end else begin
			wr_need = send_lf ? TX_CW'(1) : TX_CW'(0);
		end
		wr_room = (TX_CW'(TX_DEPTH) - tx_cnt_q) >= wr_need;
		if (func == FUNC_RX_BYTE) begin
			send_en = (ch_in != CH_ETX);
		end else begin
			send_en = (func == FUNC_APP_WRITE) && wr_room;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func)
						FUNC_RX_BYTE, FUNC_APP_WRITE: begin
							if (send_en && tx_busy_q && send_lf) begin
								state_d = ST_PUSH2;
							end
						end
						FUNC_TX_DONE: begin
							if (tx_cnt_q != '0) begin
								state_d = ST_FETCH;
							end
						end
						FUNC_APP_READ: begin
							if (rx_cnt_q != '0) begin
								state_d = ST_FETCH;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_PUSH2: state_d = ST_IDLE;
			ST_FETCH: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Ring updates, memory requests and result assembly
	always_comb begin
		rx_head_d = rx_head_q;
		rx_cnt_d  = rx_cnt_q;
		tx_head_d = tx_head_q;
		tx_cnt_d  = tx_cnt_q;
		tx_busy_d = tx_busy_q;
		out_load  = 1'b0;
		out_d     = '0;

		rx_req.we    = 1'b0;
		rx_req.waddr = rx_tail;
		rx_req.wdata = rx_byte;
		rx_req.raddr = rx_head_q;
		tx_req.we    = 1'b0;
		tx_req.waddr = tx_tail;
		tx_req.wdata = tx_busy_q ? first_byte : send_byte;
		tx_req.raddr = tx_head_q;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func)
						FUNC_RX_BYTE, FUNC_APP_WRITE: begin
							out_load = 1'b1;
							out_d.write_accepted = (func == FUNC_APP_WRITE) && send_en;
							// Send first byte straight to an idle transmitter, else queue
							if (send_en) begin
								if (!tx_busy_q) begin
									out_d.tx_load = 1'b1;
									out_d.tx_byte = first_byte;
									tx_busy_d     = 1'b1;
									if (send_lf && tx_room) begin
										tx_req.we = 1'b1;
										tx_cnt_d  = tx_cnt_q + TX_CW'(1);
									end
								end else if (tx_room) begin
									tx_req.we = 1'b1;
									tx_cnt_d  = tx_cnt_q + TX_CW'(1);
								end
							end
							// Store the received byte; drop zero, flag a full ring
							if (func == FUNC_RX_BYTE && rx_byte != 8'h00) begin
								if (rx_full) begin
									out_d.rx_overflow = 1'b1;
								end else begin
									rx_req.we = 1'b1;
									rx_cnt_d  = rx_cnt_q + RX_CW'(1);
								end
							end
						end
						FUNC_TX_DONE: begin
							if (tx_cnt_q != '0) begin
								tx_head_d = tx_head_inc;
								tx_cnt_d  = tx_cnt_q - TX_CW'(1);
								tx_busy_d = 1'b1;
							end else begin
								tx_busy_d = 1'b0;
								out_load  = 1'b1;
							end
						end
						FUNC_APP_READ: begin
							if (rx_cnt_q != '0) begin
								rx_head_d = rx_head_inc;
								rx_cnt_d  = rx_cnt_q - RX_CW'(1);
							end else begin
								out_load = 1'b1;
							end
						end
						default: out_load = 1'b0;
					endcase
				end
			end
			ST_PUSH2: begin
				// Queue the LF that follows a queued CR
				tx_req.wdata = CH_LF;
				if (tx_room) begin
					tx_req.we = 1'b1;
					tx_cnt_d  = tx_cnt_q + TX_CW'(1);
				end
			end
			ST_FETCH: begin
				// Hand out the byte read from the ring
				out_load = 1'b1;
				if (fetch_rx_q) begin
					out_d.read_valid = 1'b1;
					out_d.read_byte  = rx_rdata;
					out_d.read_end   = (rx_rdata == CH_ETX);
				end else begin
					out_d.tx_load = 1'b1;
					out_d.tx_byte = tx_rdata;
				end
			end
			default: out_load = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rx_head_q   <= '0;
			rx_cnt_q    <= '0;
			tx_head_q   <= '0;
			tx_cnt_q    <= '0;
			tx_busy_q   <= 1'b0;
			fetch_rx_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rx_head_q <= rx_head_d;
			rx_cnt_q  <= rx_cnt_d;
			tx_head_q <= tx_head_d;
			tx_cnt_q  <= tx_cnt_d;
			tx_busy_q <= tx_busy_d;
			if (accept) begin
				fetch_rx_q <= (func == FUNC_APP_READ);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

endmodule

// ===== design/uart_console_line_buffer_top.sv =====
// Top level of the UART console line buffer: sequencer and the two ring memories.
//
// Usage: in_ch carries one event per transfer (func: received byte, transmit
// done, application write, application read; data_byte for the first and
// third). out_ch returns exactly one result per event: a byte for the
// transmitter, a byte popped for the application, the write acceptance and
// the receive overflow flag.
// Both rings live in synchronous RAMs with registered read data.
// The result is valid in the cycle after the input transfer; a pop (transmit
// done with bytes queued, or a read of a non-empty receive ring) waits on the
// RAM read in ST_FETCH before the result register loads.
// Throughput: one event per cycle while out_ch takes results; a pop, and an LF
// sent while the transmitter is busy (its CR and LF need two writes to the one
// RAM write port), hold in_ch.ready low through ST_FETCH or ST_PUSH2.
// The result register is the only output stage: while out_ch stalls with a
// result held, in_ch.ready stays low and no event is taken.
// Reset (arst_n low) empties both rings and marks the transmitter idle; the
// RAM contents are not cleared, as only written entries are ever read.
module uart_console_line_buffer_top import ucl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ucl_in_if.sink    in_ch,
	ucl_out_if.source out_ch
);

	rx_mem_req_t rx_req;
	tx_mem_req_t tx_req;
	logic [7:0]  rx_rdata;
	logic [7:0]  tx_rdata;

	ucl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.rx_req   (rx_req),
		.rx_rdata (rx_rdata),
		.tx_req   (tx_req),
		.tx_rdata (tx_rdata)
	);

	ucl_ram #(
		.Depth (RX_DEPTH),
		.Width (8)
	) u_rx_ram (
		.clk   (clk),
		.we    (rx_req.we),
		.waddr (rx_req.waddr),
		.wdata (rx_req.wdata),
		.raddr (rx_req.raddr),
		.rdata (rx_rdata)
	);

	ucl_ram #(
		.Depth (TX_DEPTH),
		.Width (8)
	) u_tx_ram (
		.clk   (clk),
		.we    (tx_req.we),
		.waddr (tx_req.waddr),
		.wdata (tx_req.wdata),
		.raddr (tx_req.raddr),
		.rdata (tx_rdata)
	);

	// A held result blocks new events
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
		else $error("event taken while a result is stalled");

	// The receive ring is written only on a transfer of a received byte
	a_rx_write_on_rx_event: assert property (@(posedge clk) disable iff (!arst_n)
		rx_req.we |-> (in_ch.valid && in_ch.ready && in_ch.data.func == FUNC_RX_BYTE))
		else $error("receive ring written without a received byte");

	// A read result never also loads the transmitter, accepts a write or flags overflow
	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.data.read_valid &&
		(out_ch.data.tx_load || out_ch.data.write_accepted || out_ch.data.rx_overflow)))
		else $error("read result mixed with another event's result");

	// An accepted event is always followed by a valid result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |-> ##[1:2] out_ch.valid)
		else $error("no result follows an accepted event");

endmodule

// ===== tb/tb_uart_console_line_buffer_top.sv =====
// Self-checking testbench of the UART console line buffer: directed and random event traffic.
module tb_uart_console_line_buffer_top import ucl_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_EVENTS = 1925;
	localparam int STALL_LIMIT   = 1000;
	localparam int DRAIN_CYCLES  = 10;

	// Console state mirror: computes the result of every accepted event and checks it
	class console_scoreboard;
		logic [7:0]       rx_mem[RX_DEPTH];
		logic [RX_AW-1:0] rx_head;
		logic [RX_CW-1:0] rx_count;
		logic [7:0]       tx_mem[TX_DEPTH];
		logic [TX_AW-1:0] tx_head;
		logic [TX_CW-1:0] tx_count;
		logic             tx_busy;
		out_item_t        results_due[$];
		int               errors;

		function new();
			rx_head  = '0;
			rx_count = '0;
			tx_head  = '0;
			tx_count = '0;
			tx_busy  = 1'b0;
			errors   = 0;
		endfunction

		// Hand a byte to an idle transmitter, else queue it (drop when full)
		function void transmit(logic [7:0] b, inout out_item_t r);
			logic [TX_AW-1:0] slot;
			if (!tx_busy) begin
				r.tx_load = 1'b1;
				r.tx_byte = b;
				tx_busy   = 1'b1;
			end else if (tx_count < TX_DEPTH) begin
				slot         = tx_head + tx_count[TX_AW-1:0];
				tx_mem[slot] = b;
				tx_count++;
			end
		endfunction

		// Advance the mirror by one event and queue the result it must produce
		function void note_event(in_item_t ev);
			out_item_t        r;
			logic [7:0]       ch;
			logic [RX_AW-1:0] slot;
			int               need;
			r  = '0;
			ch = ev.data_byte;
			case (ev.func)
				FUNC_RX_BYTE: begin
					if (ch != CH_ETX) begin
						if (ch == CH_CR)
							ch = CH_LF;
						if (ch == CH_LF)
							transmit(CH_CR, r);
						transmit(ch, r);
					end
					if (ch != 8'h00) begin
						if (rx_count >= RX_DEPTH) begin
							r.rx_overflow = 1'b1;
						end else begin
							slot         = rx_head + rx_count[RX_AW-1:0];
							rx_mem[slot] = ch;
							rx_count++;
						end
					end
				end
				FUNC_TX_DONE: begin
					if (tx_count > 0) begin
						r.tx_load = 1'b1;
						r.tx_byte = tx_mem[tx_head];
						tx_head++;
						tx_count--;
						tx_busy = 1'b1;
					end else begin
						tx_busy = 1'b0;
					end
				end
				FUNC_APP_WRITE: begin
					// LF goes out as CR then LF; only bytes that cannot load directly need room
					need = (ch == CH_LF) ? 2 : 1;
					if (!tx_busy)
						need--;
					if (TX_DEPTH - int'(tx_count) >= need) begin
						if (ch == CH_LF)
							transmit(CH_CR, r);
						transmit(ch, r);
						r.write_accepted = 1'b1;
					end
				end
				default: begin
					if (rx_count > 0) begin
						r.read_valid = 1'b1;
						r.read_byte  = rx_mem[rx_head];
						r.read_end   = (rx_mem[rx_head] == CH_ETX);
						rx_head++;
						rx_count--;
					end
				end
			endcase
			results_due.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t ns: %s expected %h actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		// Compare a result transfer with the oldest expectation
		function void check_result(out_item_t got);
			out_item_t want;
			if (results_due.size() == 0) begin
				$display("%0t ns: unexpected result expected none actual %h", $time, got);
				errors++;
				return;
			end
			want = results_due.pop_front();
			compare_field("tx_load", 8'(want.tx_load), 8'(got.tx_load));
			compare_field("tx_byte", want.tx_byte, got.tx_byte);
			compare_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
			compare_field("read_byte", want.read_byte, got.read_byte);
			compare_field("read_end", 8'(want.read_end), 8'(got.read_end));
			compare_field("write_accepted", 8'(want.write_accepted),
				8'(got.write_accepted));
			compare_field("rx_overflow", 8'(want.rx_overflow), 8'(got.rx_overflow));
		endfunction

		function int outstanding();
			return results_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ucl_in_if  in_ch();
	ucl_out_if out_ch();

	uart_console_line_buffer_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	console_scoreboard sb;
	int                src_calm;
	int                snk_calm;
	int                idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random gap before the next transfer, with occasional back-to-back runs
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 40) == 0)
			calm = $urandom_range(10, 60);
		return $urandom_range(0, 18);
	endfunction

	function automatic in_item_t make_event(logic [1:0] func, logic [7:0] b);
		in_item_t ev;
		ev.func      = func;
		ev.data_byte = b;
		return ev;
	endfunction

	// Byte with a bias toward the characters the console treats specially
	function automatic logic [7:0] console_byte();
		case ($urandom_range(0, 15))
			0: return CH_CR;
			1: return CH_LF;
			2: return CH_ETX;
			3: return 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Drive one event and hold it until the transfer
	task automatic feed_event(in_item_t ev);
		int gap;
		gap = draw_gap(src_calm);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= ev;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.note_event(ev);
	endtask

	task automatic run_directed();
		// An idle read and a transmit done on an empty console
		feed_event(make_event(FUNC_APP_READ, 8'hFF));
		feed_event(make_event(FUNC_TX_DONE, 8'hFF));
		// Zero echoes straight to the idle transmitter, the rest queue
		feed_event(make_event(FUNC_RX_BYTE, 8'h00));
		feed_event(make_event(FUNC_RX_BYTE, 8'hFF));
		feed_event(make_event(FUNC_RX_BYTE, CH_CR));
		feed_event(make_event(FUNC_RX_BYTE, CH_LF));
		feed_event(make_event(FUNC_RX_BYTE, CH_ETX));
		// Writes while busy: LF needs two slots
		feed_event(make_event(FUNC_APP_WRITE, CH_LF));
		feed_event(make_event(FUNC_APP_WRITE, 8'hAA));
		// Read back the line, ending with end of input
		repeat (4)
			feed_event(make_event(FUNC_APP_READ, 8'h00));
		// Drain the transmit ring and let the transmitter go idle
		repeat (9)
			feed_event(make_event(FUNC_TX_DONE, 8'h00));
		// LF on an idle transmitter: CR loads, LF queues
		feed_event(make_event(FUNC_APP_WRITE, CH_LF));
		feed_event(make_event(FUNC_APP_WRITE, 8'h00));
		feed_event(make_event(FUNC_APP_READ, 8'h55));
	endtask

	// Random phases: typed lines, application reads, printouts, transmitter drain, noise
	task automatic run_random(int budget);
		int sent;
		int len;
		int phase;
		sent = 0;
		while (sent < budget) begin
			phase = $urandom_range(0, 4);
			len   = (phase == 4) ? $urandom_range(1, 10) : $urandom_range(1, 24);
			repeat (len) begin
				case (phase)
					0: feed_event(make_event(FUNC_RX_BYTE, console_byte()));
					1: feed_event(make_event(FUNC_APP_READ, 8'($urandom_range(0, 255))));
					2: feed_event(make_event(FUNC_APP_WRITE, console_byte()));
					3: feed_event(make_event(FUNC_TX_DONE, 8'($urandom_range(0, 255))));
					default: feed_event(make_event(2'($urandom_range(0, 3)),
						8'($urandom_range(0, 255))));
				endcase
			end
			sent += len;
		end
	endtask

	// Result side: stall at random and check each transfer
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(snk_calm);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_ch.valid);
			sb.check_result(out_ch.data);
		end
	end

	// Stop a run that makes no progress
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_uart_console_line_buffer_top failed");
			$finish;
		end
	end

	// Reset, stimulus and end of run
	initial begin
		sb          = new();
		src_calm    = 0;
		snk_calm    = 0;
		idle_cycles = 0;
		arst_n      = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random(RANDOM_EVENTS);
		in_ch.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("tb_uart_console_line_buffer_top passed");
		end else begin
			$display("tb_uart_console_line_buffer_top failed");
		end
		$finish;
	end

endmodule
